// ===== hw/rtl/forced_nucleation_friction_defines.svh =====
// Assertion macros for the forced nucleation friction block.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef FORCED_NUCLEATION_FRICTION_DEFINES_SVH
`define FORCED_NUCLEATION_FRICTION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FNF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset as well.
`define FNF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fnf_pkg.sv =====
// Shared types and constants for the forced nucleation friction block.
// No dependencies; fnf_front, fnf_core, fnf_blend and the top level use it by scoped names.
`timescale 1ns / 1ps
package fnf_pkg;

  localparam int unsigned DIV1_STEPS = 31;  // quotient bits of the radius division
  localparam int unsigned SQRT_STEPS = 32;  // result bits of the distance square root
  localparam int unsigned DIV2_STEPS = 16;  // quotient bits of the friction blend

  localparam logic [2:0] REG_WINDOW_START = 3'd0;
  localparam logic [2:0] REG_WINDOW_END   = 3'd1;
  localparam logic [2:0] REG_RADIUS_START = 3'd2;
  localparam logic [2:0] REG_RADIUS_END   = 3'd3;
  localparam logic [2:0] REG_CENTRE_X     = 3'd4;
  localparam logic [2:0] REG_CENTRE_Y     = 3'd5;

  localparam logic signed [31:0] RST_WINDOW_START = 32'sd0;
  localparam logic signed [31:0] RST_WINDOW_END   = 32'sd65536;
  localparam logic [30:0]        RST_RADIUS_START = 31'd0;
  localparam logic [30:0]        RST_RADIUS_END   = 31'd4096000;
  localparam logic signed [31:0] RST_CENTRE_X     = 32'sd0;
  localparam logic signed [31:0] RST_CENTRE_Y     = 32'sd0;

  typedef struct packed {
    logic signed [31:0] window_start;
    logic signed [31:0] window_end;
    logic [30:0]        radius_start;
    logic [30:0]        radius_end;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
  } cfg_t;

  // Values that ride alongside the iterative units untouched.
  typedef struct packed {
    logic        in_win;
    logic        span_zero;
    logic        dneg;
    logic        far;
    logic [30:0] adx;
    logic [30:0] ady;
    logic [62:0] sum;
    logic        mneg;
    logic [15:0] mmag;
    logic [15:0] base;
  } side_t;

  typedef struct packed {
    logic [62:0] rem;
    logic [31:0] span;
    logic [30:0] q;
    logic [63:0] n;
    logic [63:0] root;
    side_t       side;
  } core_t;

  typedef struct packed {
    logic [47:0] rem;
    logic [30:0] r;
    logic [15:0] corr;
    logic        in_rad;
    logic        mneg;
    logic [15:0] base;
  } blend_t;

endpackage

// ===== hw/rtl/fnf_in_if.sv =====
// Input channel: one fault point per transfer.
// Depends on nothing.
`timescale 1ns / 1ps
interface fnf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] sim_time;
  logic [15:0]        base_friction;
  logic [15:0]        weak_friction;
  modport source (output valid, point_x, point_y, sim_time, base_friction, weak_friction,
                  input ready);
  modport sink (input valid, point_x, point_y, sim_time, base_friction, weak_friction,
                output ready);
endinterface

// ===== hw/rtl/fnf_out_if.sv =====
// Result channel: one friction value per transfer.
// Depends on nothing.
`timescale 1ns / 1ps
interface fnf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] friction_out;
  logic        inside_region;
  modport source (output valid, friction_out, inside_region, input ready);
  modport sink (input valid, friction_out, inside_region, output ready);
endinterface

// ===== hw/rtl/fnf_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on nothing.
`timescale 1ns / 1ps
interface fnf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/fnf_front.sv =====
// Front end: window test, differences, then the three wide products.
// Depends on fnf_pkg.
`timescale 1ns / 1ps
module fnf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  fnf_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] sim_time,
  input  logic [15:0]        base_friction,
  input  logic [15:0]        weak_friction,
  output logic               out_valid,
  output fnf_pkg::core_t     out_item
);

  // Stage 1 registers
  logic        v1_r;
  logic [31:0] e_r, span_r;
  logic        span_zero_r, in_win_r, dneg_r, far1_r;
  logic [30:0] dmag_r, adx1_r, ady1_r;
  logic [15:0] base1_r, weak_r;
  logic [31:0] e_nxt, span_nxt;
  logic        span_zero_nxt, in_win_nxt, dneg_nxt, far1_nxt;
  logic [30:0] dmag_nxt, adx1_nxt, ady1_nxt;

  // Stage 2 registers
  logic        v2_r;
  logic [62:0] prod_r;
  logic [61:0] sqx_r, sqy_r;
  logic [31:0] span2_r;
  logic        span_zero2_r, in_win2_r, dneg2_r, far2_r, mneg_r;
  logic [30:0] adx2_r, ady2_r;
  logic [15:0] mmag_r, base2_r;
  logic [15:0] mmag_nxt;
  logic        mneg_nxt;

  // Stage 3 register
  logic           v3_r;
  fnf_pkg::core_t item_r, item_nxt;

  always_comb begin
    logic signed [32:0] e_s, span_s, d_s, dx_s, dy_s;
    logic signed [32:0] adx_s, ady_s;
    e_s    = {sim_time[31], sim_time} - {cfg.window_start[31], cfg.window_start};
    span_s = {cfg.window_end[31], cfg.window_end} - {cfg.window_start[31], cfg.window_start};
    d_s    = $signed({2'b00, cfg.radius_end}) - $signed({2'b00, cfg.radius_start});
    dx_s   = {point_x[31], point_x} - {cfg.centre_x[31], cfg.centre_x};
    dy_s   = {point_y[31], point_y} - {cfg.centre_y[31], cfg.centre_y};
    adx_s  = dx_s[32] ? -dx_s : dx_s;
    ady_s  = dy_s[32] ? -dy_s : dy_s;
    in_win_nxt    = (sim_time >= cfg.window_start) && (sim_time <= cfg.window_end);
    e_nxt         = e_s[31:0];
    span_nxt      = span_s[31:0];
    span_zero_nxt = (span_s == 33'sd0);
    dneg_nxt      = d_s[32];
    dmag_nxt      = d_s[32] ? 31'(-d_s) : d_s[30:0];
    // Any offset of 2^31 or more lies beyond every possible radius.
    far1_nxt      = adx_s[31] | ady_s[31];
    adx1_nxt      = adx_s[30:0];
    ady1_nxt      = ady_s[30:0];
  end

  always_comb begin
    logic signed [16:0] m_s;
    m_s      = $signed({1'b0, base1_r}) - $signed({1'b0, weak_r});
    mneg_nxt = m_s[16];
    mmag_nxt = m_s[16] ? 16'(-m_s) : m_s[15:0];
  end

  always_comb begin
    item_nxt                = '0;
    item_nxt.rem            = prod_r;
    item_nxt.span           = span2_r;
    item_nxt.q              = '0;
    item_nxt.n              = {1'b0, {1'b0, sqx_r} + {1'b0, sqy_r}};
    item_nxt.root           = '0;
    item_nxt.side.in_win    = in_win2_r;
    item_nxt.side.span_zero = span_zero2_r;
    item_nxt.side.dneg      = dneg2_r;
    item_nxt.side.far       = far2_r;
    item_nxt.side.adx       = adx2_r;
    item_nxt.side.ady       = ady2_r;
    item_nxt.side.sum       = {1'b0, sqx_r} + {1'b0, sqy_r};
    item_nxt.side.mneg      = mneg_r;
    item_nxt.side.mmag      = mmag_r;
    item_nxt.side.base      = base2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r          <= e_nxt;
      span_r       <= span_nxt;
      span_zero_r  <= span_zero_nxt;
      in_win_r     <= in_win_nxt;
      dneg_r       <= dneg_nxt;
      dmag_r       <= dmag_nxt;
      far1_r       <= far1_nxt;
      adx1_r       <= adx1_nxt;
      ady1_r       <= ady1_nxt;
      base1_r      <= base_friction;
      weak_r       <= weak_friction;
      prod_r       <= {32'd0, dmag_r} * {31'd0, e_r};
      sqx_r        <= {31'd0, adx1_r} * {31'd0, adx1_r};
      sqy_r        <= {31'd0, ady1_r} * {31'd0, ady1_r};
      span2_r      <= span_r;
      span_zero2_r <= span_zero_r;
      in_win2_r    <= in_win_r;
      dneg2_r      <= dneg_r;
      far2_r       <= far1_r;
      adx2_r       <= adx1_r;
      ady2_r       <= ady1_r;
      mneg_r       <= mneg_nxt;
      mmag_r       <= mmag_nxt;
      base2_r      <= base1_r;
      item_r       <= item_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_item  = item_r;

endmodule

// ===== hw/rtl/fnf_core.sv =====
// Pipelined radius divider and distance square root, one result bit per stage.
// Depends on fnf_pkg.
`timescale 1ns / 1ps
module fnf_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  fnf_pkg::core_t in_item,
  output logic           out_valid,
  output fnf_pkg::core_t out_item
);

  localparam int unsigned N = fnf_pkg::SQRT_STEPS;

  logic           v_r  [N];
  fnf_pkg::core_t st_r [N];
  fnf_pkg::core_t st_nxt [N];
  logic           v_in [N];
  fnf_pkg::core_t st_in [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign v_in[k]  = in_valid;
      assign st_in[k] = in_item;
    end else begin : g_rest
      assign v_in[k]  = v_r[k-1];
      assign st_in[k] = st_r[k-1];
    end

    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
    // Quotient bit of this stage; stages past the division keep a legal index.
    localparam int unsigned QBIT = (k < fnf_pkg::DIV1_STEPS) ?
                                   (fnf_pkg::DIV1_STEPS - 1 - k) : 0;

    always_comb begin
      logic [63:0] trial;
      logic [63:0] dsub;
      st_nxt[k] = st_in[k];
      dsub      = '0;
      // Radius division: restoring step on quotient bit QBIT.
      if (k < fnf_pkg::DIV1_STEPS) begin
        dsub = {32'd0, st_in[k].span} << QBIT;
        if ({1'b0, st_in[k].rem} >= dsub) begin
          st_nxt[k].rem = st_in[k].rem - dsub[62:0];
          st_nxt[k].q[QBIT] = 1'b1;
        end
      end
      // Square root: one pair of radicand bits.
      trial = st_in[k].root + SQ_BIT;
      if (st_in[k].n >= trial) begin
        st_nxt[k].n    = st_in[k].n - trial;
        st_nxt[k].root = (st_in[k].root >> 1) + SQ_BIT;
      end else begin
        st_nxt[k].root = st_in[k].root >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_item  = st_r[N-1];

endmodule

// ===== hw/rtl/fnf_blend.sv =====
// Back end: radius, inside test, blend numerator, pipelined blend division
// and the result register. Depends on fnf_pkg.
`timescale 1ns / 1ps
module fnf_blend (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  fnf_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  fnf_pkg::core_t in_item,
  output logic           out_valid,
  output logic [15:0]    friction_out,
  output logic           inside_region
);

  localparam int unsigned N = fnf_pkg::DIV2_STEPS;

  // Radius stage
  logic           v0_r;
  logic [30:0]    r0_r, r0_nxt;
  logic [31:0]    dist0_r;
  fnf_pkg::side_t side0_r;

  // Product stage
  logic           v1_r;
  logic [61:0]    rr_r;
  logic [46:0]    nump_r;
  logic [30:0]    r1_r;
  fnf_pkg::side_t side1_r;

  // Division entry
  logic            v2_r;
  fnf_pkg::blend_t b2_r, b2_nxt;

  logic            dv_r  [N];
  fnf_pkg::blend_t ds_r  [N];
  fnf_pkg::blend_t ds_nxt [N];
  logic            dv_in [N];
  fnf_pkg::blend_t ds_in [N];

  logic        vo_r;
  logic [15:0] fric_r, fric_nxt;
  logic        inside_r;

  always_comb begin
    if (in_item.side.span_zero) begin
      r0_nxt = cfg.radius_end;
    end else if (in_item.side.dneg) begin
      r0_nxt = cfg.radius_start - in_item.q;
    end else begin
      r0_nxt = cfg.radius_start + in_item.q;
    end
  end

  always_comb begin
    b2_nxt        = '0;
    b2_nxt.r      = r1_r;
    b2_nxt.rem    = {1'b0, nump_r} + {18'd0, r1_r[30:1]};
    b2_nxt.corr   = '0;
    b2_nxt.in_rad = side1_r.in_win && (r1_r != 31'd0) && !side1_r.far &&
                    (side1_r.adx <= r1_r) && (side1_r.ady <= r1_r) &&
                    (side1_r.sum <= {1'b0, rr_r});
    b2_nxt.mneg   = side1_r.mneg;
    b2_nxt.base   = side1_r.base;
  end

  for (genvar j = 0; j < N; j++) begin : g_div
    if (j == 0) begin : g_first
      assign dv_in[j] = v2_r;
      assign ds_in[j] = b2_r;
    end else begin : g_rest
      assign dv_in[j] = dv_r[j-1];
      assign ds_in[j] = ds_r[j-1];
    end

    always_comb begin
      logic [47:0] dsub;
      ds_nxt[j] = ds_in[j];
      dsub      = {17'd0, ds_in[j].r} << (N - 1 - j);
      if (ds_in[j].rem >= dsub) begin
        ds_nxt[j].rem = ds_in[j].rem - dsub;
        ds_nxt[j].corr[N - 1 - j] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (adv) begin
        dv_r[j] <= dv_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ds_r[j] <= ds_nxt[j];
      end
    end
  end

  always_comb begin
    if (!ds_r[N-1].in_rad) begin
      fric_nxt = ds_r[N-1].base;
    end else if (ds_r[N-1].mneg) begin
      fric_nxt = ds_r[N-1].base + ds_r[N-1].corr;
    end else begin
      fric_nxt = ds_r[N-1].base - ds_r[N-1].corr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      vo_r <= dv_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r0_r     <= r0_nxt;
      dist0_r  <= in_item.root[31:0];
      side0_r  <= in_item.side;
      rr_r     <= {31'd0, r0_r} * {31'd0, r0_r};
      // Outside the radius the difference wraps; the result is then unused.
      nump_r   <= {31'd0, side0_r.mmag} * {16'd0, r0_r - dist0_r[30:0]};
      r1_r     <= r0_r;
      side1_r  <= side0_r;
      b2_r     <= b2_nxt;
      fric_r   <= fric_nxt;
      inside_r <= ds_r[N-1].in_rad;
    end
  end

  assign out_valid     = vo_r;
  assign friction_out  = fric_r;
  assign inside_region = inside_r;

endmodule

// ===== hw/rtl/forced_nucleation_friction.sv =====
// Forced nucleation friction weakening, fully pipelined.
//
// in_chan carries one fault point per transfer (coordinates, time, base and
// weakened friction); out_chan returns one friction value and an inside flag
// per point, in order. cfg_chan writes the six window, radius and centre
// registers; it is always ready and must only be used while the pipeline is
// empty.
// The pipeline has 55 register stages: three front stages (differences,
// products), 32 square-root stages that also carry the 31-bit radius
// division, three radius and product stages, 16 blend division stages and
// the output register. One point enters per cycle unless a result waits on
// out_chan with ready low.
// The whole pipeline advances together: while a result waits on out_chan
// with ready low, no stage moves and in_chan.ready is low; nothing is dropped
// or repeated. Reset loads the default configuration and clears all valid
// bits; results emerge once reset is released.
// Depends on fnf_pkg, the channel interfaces, fnf_front, fnf_core, fnf_blend
// and the assertion macro header.
`timescale 1ns / 1ps
`include "forced_nucleation_friction_defines.svh"
module forced_nucleation_friction (
  input  logic clk,
  input  logic rst_n,
  fnf_in_if.sink    in_chan,
  fnf_out_if.source out_chan,
  fnf_cfg_if.sink   cfg_chan
);

  fnf_pkg::cfg_t cfg_r, cfg_nxt;
  logic          adv;
  logic          front_v, core_v, blend_v;
  fnf_pkg::core_t front_item, core_item;

  assign adv            = !blend_v || out_chan.ready;
  assign in_chan.ready  = adv;
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        fnf_pkg::REG_WINDOW_START: cfg_nxt.window_start = cfg_chan.data;
        fnf_pkg::REG_WINDOW_END:   cfg_nxt.window_end   = cfg_chan.data;
        fnf_pkg::REG_RADIUS_START: cfg_nxt.radius_start = cfg_chan.data[30:0];
        fnf_pkg::REG_RADIUS_END:   cfg_nxt.radius_end   = cfg_chan.data[30:0];
        fnf_pkg::REG_CENTRE_X:     cfg_nxt.centre_x     = cfg_chan.data;
        fnf_pkg::REG_CENTRE_Y:     cfg_nxt.centre_y     = cfg_chan.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_start <= fnf_pkg::RST_WINDOW_START;
      cfg_r.window_end   <= fnf_pkg::RST_WINDOW_END;
      cfg_r.radius_start <= fnf_pkg::RST_RADIUS_START;
      cfg_r.radius_end   <= fnf_pkg::RST_RADIUS_END;
      cfg_r.centre_x     <= fnf_pkg::RST_CENTRE_X;
      cfg_r.centre_y     <= fnf_pkg::RST_CENTRE_Y;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fnf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .cfg           (cfg_r),
    .in_valid      (in_chan.valid),
    .point_x       (in_chan.point_x),
    .point_y       (in_chan.point_y),
    .sim_time      (in_chan.sim_time),
    .base_friction (in_chan.base_friction),
    .weak_friction (in_chan.weak_friction),
    .out_valid     (front_v),
    .out_item      (front_item)
  );

  fnf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (front_v),
    .in_item   (front_item),
    .out_valid (core_v),
    .out_item  (core_item)
  );

  fnf_blend u_blend (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .cfg           (cfg_r),
    .in_valid      (core_v),
    .in_item       (core_item),
    .out_valid     (blend_v),
    .friction_out  (out_chan.friction_out),
    .inside_region (out_chan.inside_region)
  );

  assign out_chan.valid = blend_v;

  // A held result must freeze the pipeline, so no new point may enter.
  `FNF_ASSERT_NOW(a_stall_blocks_input, out_chan.valid && !out_chan.ready, !in_chan.ready, "input accepted while the result stalls")
  // Reset empties the pipeline.
  `FNF_ASSERT_NEXT(a_reset_clears_output, !rst_n, !out_chan.valid, "result valid right after reset")

endmodule

// ===== dv/fnf_checker.sv =====
// Checker for the forced nucleation friction block: watches all three channels,
// predicts each result and compares it. Depends on fnf_pkg and the channel interfaces.
`timescale 1ns / 1ps
module fnf_checker (
  input  logic clk,
  input  logic rst_n,
  fnf_in_if    in_chan,
  fnf_out_if   out_chan,
  fnf_cfg_if   cfg_chan,
  output int   errors,
  output int   pending
);

  typedef struct {
    logic [15:0] friction;
    logic        in_region;
  } friction_result_t;

  friction_result_t expected_frictions[$];

  longint win_start, win_end, rad_start, rad_end, ctr_x, ctr_y;
  int     inside_seen;

  initial begin
    errors = 0;
    pending = 0;
    inside_seen = 0;
  end

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Floor square root, one result bit per pass from the top.
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= n) root = cand;
    end
    return root;
  endfunction

  function automatic friction_result_t predict_friction(logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] t, logic [15:0] base, logic [15:0] weak_fr);
    friction_result_t res;
    longint span, d, r, m, tt;
    longint unsigned e, q, ur, adx, ady, sum, dist_v, corr;
    res.friction = base;
    res.in_region = 1'b0;
    tt = t;
    if (tt >= win_start && tt <= win_end) begin
      span = win_end - win_start;
      if (span == 0) begin
        r = rad_end;
      end else begin
        d = rad_end - rad_start;
        e = tt - win_start;
        q = magnitude(d) * e / longint'(span);
        r = (d < 0) ? rad_start - longint'(q) : rad_start + longint'(q);
      end
      if (r > 0) begin
        ur = r;
        adx = magnitude(longint'(px) - ctr_x);
        ady = magnitude(longint'(py) - ctr_y);
        if (adx <= ur && ady <= ur) begin
          sum = adx * adx + ady * ady;
          if (sum <= ur * ur) begin
            dist_v = floor_sqrt(sum);
            m = longint'(base) - longint'(weak_fr);
            corr = (magnitude(m) * (ur - dist_v) + (ur >> 1)) / ur;
            res.friction = (m < 0) ? base + corr[15:0] : base - corr[15:0];
            res.in_region = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    friction_result_t got, want;
    if (!rst_n) begin
      win_start = fnf_pkg::RST_WINDOW_START;
      win_end   = fnf_pkg::RST_WINDOW_END;
      rad_start = {33'd0, fnf_pkg::RST_RADIUS_START};
      rad_end   = {33'd0, fnf_pkg::RST_RADIUS_END};
      ctr_x     = fnf_pkg::RST_CENTRE_X;
      ctr_y     = fnf_pkg::RST_CENTRE_Y;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          fnf_pkg::REG_WINDOW_START: win_start = longint'($signed(cfg_chan.data));
          fnf_pkg::REG_WINDOW_END:   win_end   = longint'($signed(cfg_chan.data));
          fnf_pkg::REG_RADIUS_START: rad_start = {33'd0, cfg_chan.data[30:0]};
          fnf_pkg::REG_RADIUS_END:   rad_end   = {33'd0, cfg_chan.data[30:0]};
          fnf_pkg::REG_CENTRE_X:     ctr_x     = longint'($signed(cfg_chan.data));
          fnf_pkg::REG_CENTRE_Y:     ctr_y     = longint'($signed(cfg_chan.data));
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready)
        expected_frictions.push_back(predict_friction(in_chan.point_x, in_chan.point_y,
            in_chan.sim_time, in_chan.base_friction, in_chan.weak_friction));
      if (out_chan.valid && out_chan.ready) begin
        got.friction = out_chan.friction_out;
        got.in_region = out_chan.inside_region;
        if (expected_frictions.size() == 0) begin
          report_mismatch("result transfer with no point outstanding");
        end else begin
          want = expected_frictions.pop_front();
          if (want.in_region) inside_seen++;
          if (got.friction !== want.friction)
            report_mismatch($sformatf("friction_out %h, expected %h", got.friction,
                want.friction));
          if (got.in_region !== want.in_region)
            report_mismatch($sformatf("inside_region %b, expected %b", got.in_region,
                want.in_region));
        end
      end
    end
    pending <= expected_frictions.size();
  end
endmodule

// ===== dv/tb_forced_nucleation_friction.sv =====
// Testbench top for the forced nucleation friction block: drives points and register
// writes, stalls the result side, and reports the verdict. Depends on fnf_pkg,
// the channel interfaces, the block and fnf_checker.
`timescale 1ns / 1ps
module tb_forced_nucleation_friction;

  logic clk;
  logic rst_n;
  int   errors, pending;
  int   points_sent;
  bit   calm;
  bit   hold_start;
  int   hold_left;

  // Stimulus-side copy of the settings, used only to aim points and times.
  longint cur_ws, cur_we, cur_rs, cur_re, cur_cx, cur_cy;

  fnf_in_if  in_chan ();
  fnf_out_if out_chan ();
  fnf_cfg_if cfg_chan ();

  forced_nucleation_friction i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  fnf_checker i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stalls, quiet stretches, and one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b1;
    end else begin
      if (hold_start) begin
        hold_left = 300;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (calm) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= 15);
      end
    end
  end

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] t,
      logic [15:0] base, logic [15:0] weak_fr);
    if (!calm && $urandom_range(0, 99) < 15) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.point_x <= px;
    in_chan.point_y <= py;
    in_chan.sim_time <= t;
    in_chan.base_friction <= base;
    in_chan.weak_friction <= weak_fr;
    @(negedge clk);
    while (!in_chan.ready) @(negedge clk);
    @(posedge clk);
    points_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= value;
    @(negedge clk);
    while (!cfg_chan.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_settings(longint ws, longint we, longint rs, longint re,
      longint cx, longint cy);
    wait_drained();
    write_reg(fnf_pkg::REG_WINDOW_START, ws[31:0]);
    write_reg(fnf_pkg::REG_WINDOW_END, we[31:0]);
    write_reg(fnf_pkg::REG_RADIUS_START, rs[31:0]);
    write_reg(fnf_pkg::REG_RADIUS_END, re[31:0]);
    write_reg(fnf_pkg::REG_CENTRE_X, cx[31:0]);
    write_reg(fnf_pkg::REG_CENTRE_Y, cy[31:0]);
    cfg_chan.valid <= 1'b0;
    cur_ws = longint'($signed(ws[31:0]));
    cur_we = longint'($signed(we[31:0]));
    cur_rs = longint'(rs[30:0]);
    cur_re = longint'(re[30:0]);
    cur_cx = longint'($signed(cx[31:0]));
    cur_cy = longint'($signed(cy[31:0]));
  endtask

  function automatic logic [15:0] pick_friction();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h4000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly points near the centre at times inside the window, with some noise.
  task automatic send_random_point();
    longint lim, span;
    logic [31:0] px, py, t;
    logic [15:0] base;
    lim = (cur_rs > cur_re) ? cur_rs : cur_re;
    if (lim > (64'd1 << 29)) lim = 64'd1 << 29;
    lim = lim + 2;
    if ($urandom_range(0, 99) < 75) begin
      px = 32'(cur_cx + longint'($urandom_range(0, 32'(2 * lim))) - lim);
      py = 32'(cur_cy + longint'($urandom_range(0, 32'(2 * lim))) - lim);
    end else begin
      px = $urandom;
      py = $urandom;
    end
    span = cur_we - cur_ws;
    if (span >= 0 && $urandom_range(0, 99) < 75) begin
      case ($urandom_range(0, 19))
        0: t = cur_ws[31:0];
        1: t = cur_we[31:0];
        default: t = 32'(cur_ws + longint'({32'd0, $urandom} % (span + 1)));
      endcase
    end else begin
      t = $urandom;
    end
    base = pick_friction();
    send_point(px, py, t, base, ($urandom_range(0, 9) == 0) ? base : pick_friction());
  endtask

  task automatic run_phase(int count);
    repeat (count) send_random_point();
  endtask

  initial begin
    rst_n = 1'b0;
    calm = 1'b0;
    hold_start = 1'b0;
    hold_left = 0;
    points_sent = 0;
    in_chan.valid = 1'b0;
    in_chan.point_x = '0;
    in_chan.point_y = '0;
    in_chan.sim_time = '0;
    in_chan.base_friction = '0;
    in_chan.weak_friction = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = fnf_pkg::REG_WINDOW_START;
    cfg_chan.data = '0;
    cur_ws = fnf_pkg::RST_WINDOW_START;
    cur_we = fnf_pkg::RST_WINDOW_END;
    cur_rs = fnf_pkg::RST_RADIUS_START;
    cur_re = fnf_pkg::RST_RADIUS_END;
    cur_cx = fnf_pkg::RST_CENTRE_X;
    cur_cy = fnf_pkg::RST_CENTRE_Y;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points against the reset settings: window 0..1 s, radius 0 to 1000 m.
    send_point(32'd0, 32'd0, -32'sd1, 16'h1234, 16'h0000);        // before the window
    send_point(32'd0, 32'd0, 32'd65537, 16'h1234, 16'h0000);      // after the window
    send_point(32'd0, 32'd0, 32'd0, 16'hFFFF, 16'h0000);          // zero radius at start
    send_point(32'd0, 32'd0, 32'd65536, 16'hFFFF, 16'h0000);      // centre, full radius
    send_point(32'd0, 32'd0, 32'd65536, 16'h0000, 16'hFFFF);
    send_point(32'd4096000, 32'd0, 32'd65536, 16'h8000, 16'h1000); // on the rim
    send_point(32'd4096001, 32'd0, 32'd65536, 16'h8000, 16'h1000); // just outside
    send_point(32'd2896309, 32'd2896309, 32'd65536, 16'h4000, 16'h0001);
    send_point(32'd2048000, 32'd0, 32'd32768, 16'h4000, 16'h0000);
    send_point(32'd2048001, 32'd0, 32'd32768, 16'h4000, 16'h0000);
    send_point(-32'sd1000000, 32'd1000, 32'd50000, 16'h3000, 16'h3000); // equal frictions
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'd40000, 16'hFFFF, 16'h0000);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 16'hFFFF, 16'hFFFF);
    send_point(32'd1, 32'd1, 32'h7FFFFFFF, 16'h0001, 16'hFFFE);
    send_point(32'd12, -32'sd7, 32'd1, 16'hABCD, 16'h5432);

    // Ordinary settings; the result side holds off while points keep coming.
    load_settings(-65536, 3 * 65536, 4096, 8192000, 12345, -54321);
    run_phase(60);
    hold_start = 1'b1;
    run_phase(130);
    // The sender stops until everything outstanding has come back.
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    run_phase(40);

    // Widest window, largest radius, centre at the corners of the range.
    load_settings(-64'sd2147483648, 64'sd2147483647, 0, 64'h7FFFFFFF,
        -64'sd2147483648, 64'sd2147483647);
    calm = 1'b1;
    run_phase(100);
    calm = 1'b0;
    run_phase(90);

    // Shrinking radius, the opposite corner.
    load_settings(0, 65536, 64'h7FFFFFFF, 0, 64'sd2147483647, -64'sd2147483648);
    run_phase(170);

    // Zero time span uses the end radius.
    load_settings(1000, 1000, 5, 409600, -4096, 8192);
    run_phase(150);

    // Zero radius everywhere.
    load_settings(-100, 100000, 0, 0, 0, 0);
    run_phase(100);

    // Reversed window: nothing is ever inside.
    load_settings(65536, 0, 0, 4096000, 0, 0);
    run_phase(100);

    // Tiny radii stress the rounding of the blend.
    load_settings(0, 100, 3, 40, 7, -7);
    run_phase(180);

    // Random settings with moderate radii.
    repeat (3) begin
      load_settings(longint'($signed($urandom_range(0, 400000))) - 200000,
          longint'($urandom_range(200000, 900000)), $urandom_range(0, 1 << 20),
          $urandom_range(0, 1 << 24), longint'($signed($urandom)), longint'($signed($urandom)));
      run_phase(90);
    end

    wait_drained();
    $display("Sent %0d points over eleven register settings, including window, radius",
        points_sent);
    $display("and centre extremes, a long result hold-off and a full drain pause.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
